FILE: sv/c3cf_pkg.sv
// Shared types, constants and helpers of the 3x3 convolution filter.
package c3cf_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned COEF_ROW_W = 48;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST = 48'd0;
    localparam logic [COEF_ROW_W-1:0] COEF_MID_RST = 48'd16777216;
    localparam logic [COEF_ROW_W-1:0] COEF_BOT_RST = 48'd0;
    localparam logic [DIM_W-1:0]      WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0]      HEIGHT_RST   = 13'd480;

    localparam int unsigned OUT_DEPTH = 8;
    localparam int unsigned OUT_PTR_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP   = 3'd0,
        CFG_COEF_MID   = 3'd1,
        CFG_COEF_BOT   = 3'd2,
        CFG_IMG_WIDTH  = 3'd3,
        CFG_IMG_HEIGHT = 3'd4
    } t_cfg_idx;

    // Window as [row][column]; row 0 is the oldest line, column 0 the oldest pixel.
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic             emit;
        logic             nz;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_res;

    // Coefficient slot 0 is the left tap in the top bits of a packed row.
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [COEF_ROW_W-1:0] row,
        input logic [1:0]            slot
    );
        logic signed [COEF_W-1:0] v;
        unique case (slot)
            2'd0:    v = row[47:32];
            2'd1:    v = row[31:16];
            default: v = row[15:0];
        endcase
        return v;
    endfunction

endpackage

FILE: sv/c3cf_ifs.sv
// Handshake channel interfaces of the 3x3 convolution filter.
interface c3cf_pix_in_if import c3cf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;

    modport source (output valid, pixel_in, frame_start, input ready);
    modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface c3cf_pix_out_if import c3cf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;

    modport source (output valid, pixel_out, out_row, out_col, frame_last, input ready);
    modport sink   (input valid, pixel_out, out_row, out_col, frame_last, output ready);
endinterface

interface c3cf_cfg_if import c3cf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [COEF_ROW_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/c3cf_line_mem.sv
// Two line memories with read-modify-write forwarding and the six-pixel window.
module c3cf_line_mem import c3cf_pkg::*; #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_acc,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [PIX_W-1:0]         i_pixel,
    output logic                     o_valid,
    output t_win                     o_win
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [PIX_W-1:0] r_upper [DEPTH];
    logic [PIX_W-1:0] r_lower [DEPTH];

    logic             r_s1_v;
    logic [AW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_rd_up;
    logic [PIX_W-1:0] r_rd_lo;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_b;
    logic [PIX_W-1:0] r_fwd_p;
    logic [PIX_W-1:0] r_win [6];

    logic [PIX_W-1:0] w_a;
    logic [PIX_W-1:0] w_b;

    // When the previous item wrote the same column on the edge of this read,
    // the memory returned stale data; take the values it wrote instead.
    always_comb begin
        w_a = r_fwd ? r_fwd_b : r_rd_up;
        w_b = r_fwd ? r_fwd_p : r_rd_lo;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_upper[r_s1_addr] <= w_b;
            r_lower[r_s1_addr] <= r_s1_pix;
        end
        r_rd_up <= r_upper[i_addr];
        r_rd_lo <= r_lower[i_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_addr;
        r_s1_pix  <= i_pixel;
        r_fwd_b   <= w_b;
        r_fwd_p   <= r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_v <= i_acc;
            r_fwd  <= i_acc && r_s1_v && (r_s1_addr == i_addr);
            if (r_s1_v) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= w_a;
                r_win[4] <= w_b;
                r_win[5] <= r_s1_pix;
            end
        end
    end

    always_comb begin
        o_valid = r_s1_v;
        for (int i = 0; i < 3; i++) begin
            o_win[i][0] = r_win[i];
            o_win[i][1] = r_win[3+i];
        end
        o_win[0][2] = w_a;
        o_win[1][2] = w_b;
        o_win[2][2] = r_s1_pix;
    end

endmodule

FILE: sv/c3cf_mac.sv
// Nine-tap multiply, registered adder tree, rounding and clamping.
module c3cf_mac import c3cf_pkg::*; #(
    parameter int unsigned FRAC = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_meta                 i_meta,
    input  t_win                  i_win,
    input  logic [COEF_ROW_W-1:0] i_coef_top,
    input  logic [COEF_ROW_W-1:0] i_coef_mid,
    input  logic [COEF_ROW_W-1:0] i_coef_bot,
    output logic                  o_push,
    output t_res                  o_res
);

    localparam int unsigned PROD_W = PIX_W + 1 + COEF_W;
    localparam int unsigned ROW_W  = PROD_W + 2;
    localparam int unsigned SUM_W  = ROW_W + 2;
    localparam int unsigned RND_SH = (FRAC > 0) ? FRAC - 1 : 0;
    localparam logic signed [SUM_W-1:0] RND = (FRAC > 0) ? (SUM_W'(1) << RND_SH) : '0;

    logic [2:0][COEF_ROW_W-1:0] w_rows;

    logic                     r_s2_v;
    t_meta                    r_s2_meta;
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic                     r_s3_v;
    t_meta                    r_s3_meta;
    logic signed [ROW_W-1:0]  r_row [3];
    logic                     r_s4_v;

    logic signed [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]         w_q;
    logic [PIX_W-1:0]         w_pix;

    assign w_rows[0] = i_coef_top;
    assign w_rows[1] = i_coef_mid;
    assign w_rows[2] = i_coef_bot;

    always_ff @(posedge i_clk) begin
        r_s2_meta <= i_meta;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= $signed({1'b0, i_win[i][j]}) * coef_at(w_rows[i], 2'(j));
            end
        end
        r_s3_meta <= r_s2_meta;
        for (int i = 0; i < 3; i++) begin
            r_row[i] <= ROW_W'(r_prod[i][0]) + ROW_W'(r_prod[i][1]) + ROW_W'(r_prod[i][2]);
        end
    end

    always_comb begin
        w_sum = SUM_W'(r_row[0]) + SUM_W'(r_row[1]) + SUM_W'(r_row[2]) + RND;
        w_q   = SUM_W'(w_sum >>> FRAC);
        // Border outputs and non-positive sums give zero; large sums saturate.
        if (!r_s3_meta.nz || w_sum <= 0) begin
            w_pix = PIX_MIN;
        end else if (w_q > SUM_W'(PIX_MAX)) begin
            w_pix = PIX_MAX;
        end else begin
            w_pix = w_q[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.pixel <= w_pix;
        o_res.row   <= r_s3_meta.row;
        o_res.col   <= r_s3_meta.col;
        o_res.last  <= r_s3_meta.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s2_v <= i_valid;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v && r_s3_meta.emit;
        end
    end

    assign o_push = r_s4_v;

endmodule

FILE: sv/c3cf_out_fifo.sv
// Output queue with credit count so the pipeline never has to stall.
module c3cf_out_fifo import c3cf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    output logic                  o_room,
    input  logic                  i_push,
    input  t_res                  i_res,
    c3cf_pix_out_if.source        o_out
);

    t_res               r_mem [OUT_DEPTH];
    logic [OUT_PTR_W:0] r_wr;
    logic [OUT_PTR_W:0] r_rd;
    logic [OUT_PTR_W:0] r_cred;
    logic [OUT_PTR_W:0] w_occ;
    logic               w_pop;
    t_res               w_head;

    assign w_occ  = r_wr - r_rd;
    assign w_pop  = o_out.valid && o_out.ready;
    assign w_head = r_mem[r_rd[OUT_PTR_W-1:0]];
    assign o_room = r_cred < (OUT_PTR_W+1)'(OUT_DEPTH);

    assign o_out.valid      = (r_wr != r_rd);
    assign o_out.pixel_out  = w_head.pixel;
    assign o_out.out_row    = w_head.row;
    assign o_out.out_col    = w_head.col;
    assign o_out.frame_last = w_head.last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[OUT_PTR_W-1:0]] <= i_res;
        end
    end

    // A credit is held from acceptance of an emitting item until its result leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cred <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cred <= r_cred + (OUT_PTR_W+1)'(i_take) - (OUT_PTR_W+1)'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (w_occ < (OUT_PTR_W+1)'(OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    a_occ_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= r_cred)
        else $error("output queue holds more results than credits");

    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_room)
        else $error("item accepted without output credit");

endmodule

FILE: sv/conv3x3_clamp_filter_unit.sv
// Top level of the 3x3 convolution filter with rounding and clamping.
//
// Pixels enter on i_in in raster order, one item per clock at most; frame_start
// puts the item at row 0, column 0. For a pixel at (r,c) with r,c >= 1 the
// block emits output pixel (r-1,c-1) on o_out, with its row, column and a
// frame_last flag on output (height-2, width-2). Output row 0 and column 0
// carry zero. Registers on i_cfg (index 0..4: kernel rows top, middle, bottom,
// width, height) are to be written only while the stream is idle; the block
// does not enforce this. i_cfg is always ready. Throughput is one item per cycle
// while credits remain. A result passes registered steps: the line memories are
// read at the accepting edge, then forwarding and the nine multipliers, the row
// sums, the final sum, rounding and clamp, and the write into the output queue.
// This eight-entry queue with credits decouples the receiver: i_in.ready drops
// only when eight results are pending or in flight, so a stalled receiver never
// stops the pipeline itself. Reset clears position, window and queue and
// restores the identity kernel and a 640x480 frame; the line memories are not
// cleared, as unwritten entries only feed border zeros.
module conv3x3_clamp_filter_unit import c3cf_pkg::*; #(
    parameter int unsigned MAX_WIDTH      = 4096,
    parameter int unsigned MAX_HEIGHT     = 4096,
    parameter int unsigned COEF_FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    c3cf_pix_in_if.sink      i_in,
    c3cf_pix_out_if.source   o_out,
    c3cf_cfg_if.sink         i_cfg
);

    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CA = $clog2(MAX_WIDTH);
    localparam int unsigned RA = $clog2(MAX_HEIGHT);

    function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned hi);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'd3) begin
            return 32'd3;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    localparam logic [CW-1:0] W_RST = CW'(clamp_dim(WIDTH_RST, MAX_WIDTH));
    localparam logic [RW-1:0] H_RST = RW'(clamp_dim(HEIGHT_RST, MAX_HEIGHT));

    logic [COEF_ROW_W-1:0] r_coef_top;
    logic [COEF_ROW_W-1:0] r_coef_mid;
    logic [COEF_ROW_W-1:0] r_coef_bot;
    logic [CW-1:0]         r_w;
    logic [RW-1:0]         r_h;
    logic [CA-1:0]         r_col;
    logic [RA-1:0]         r_row;
    t_meta                 r_s1_meta;

    logic                  w_acc;
    logic                  w_room;
    logic                  w_cfg_acc;
    logic [CA-1:0]         w_c0;
    logic [RA-1:0]         w_r0;
    logic                  w_wrap;
    logic [CA-1:0]         w_c1;
    logic [RW-1:0]         w_r1w;
    logic [RA-1:0]         w_r1;
    logic [CW-1:0]         w_cn;
    logic [RW-1:0]         w_rn;
    logic [CA-1:0]         n_col;
    logic [RA-1:0]         n_row;
    t_meta                 w_meta;

    logic                  w_lm_valid;
    t_win                  w_win;
    logic                  w_push;
    t_res                  w_res;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = w_room;
    assign w_acc       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= COEF_TOP_RST;
            r_coef_mid <= COEF_MID_RST;
            r_coef_bot <= COEF_BOT_RST;
            r_w        <= W_RST;
            r_h        <= H_RST;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.index)
                CFG_COEF_TOP:   r_coef_top <= i_cfg.data;
                CFG_COEF_MID:   r_coef_mid <= i_cfg.data;
                CFG_COEF_BOT:   r_coef_bot <= i_cfg.data;
                CFG_IMG_WIDTH:  r_w <= CW'(clamp_dim(i_cfg.data[DIM_W-1:0], MAX_WIDTH));
                CFG_IMG_HEIGHT: r_h <= RW'(clamp_dim(i_cfg.data[DIM_W-1:0], MAX_HEIGHT));
                default:        ;
            endcase
        end
    end

    // Position of the arriving pixel, and of the one after it.
    always_comb begin
        w_c0   = i_in.frame_start ? '0 : r_col;
        w_r0   = i_in.frame_start ? '0 : r_row;
        w_wrap = CW'(w_c0) >= r_w;
        w_c1   = w_wrap ? '0 : w_c0;
        w_r1w  = RW'(w_r0) + RW'(w_wrap);
        if (w_r1w >= r_h) begin
            w_r1w = '0;
        end
        w_r1 = RA'(w_r1w);

        w_cn = CW'(w_c1) + CW'(1);
        w_rn = RW'(w_r1);
        if (w_cn >= r_w) begin
            w_cn = '0;
            w_rn = RW'(w_r1) + RW'(1);
            if (w_rn >= r_h) begin
                w_rn = '0;
            end
        end
        n_col = CA'(w_cn);
        n_row = RA'(w_rn);

        w_meta.emit = (w_r1 != '0) && (w_c1 != '0);
        w_meta.nz   = (RW'(w_r1) >= RW'(2)) && (CW'(w_c1) >= CW'(2));
        w_meta.last = (RW'(w_r1) == r_h - RW'(1)) && (CW'(w_c1) == r_w - CW'(1));
        w_meta.row  = POS_W'(RW'(w_r1) - RW'(1));
        w_meta.col  = POS_W'(CW'(w_c1) - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_meta <= w_meta;
    end

    c3cf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_addr  (w_c1),
        .i_pixel (i_in.pixel_in),
        .o_valid (w_lm_valid),
        .o_win   (w_win)
    );

    c3cf_mac #(
        .FRAC (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_lm_valid),
        .i_meta     (r_s1_meta),
        .i_win      (w_win),
        .i_coef_top (r_coef_top),
        .i_coef_mid (r_coef_mid),
        .i_coef_bot (r_coef_bot),
        .o_push     (w_push),
        .o_res      (w_res)
    );

    c3cf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_acc && w_meta.emit),
        .o_room  (w_room),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_out   (o_out)
    );

    a_nz_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lm_valid && r_s1_meta.nz) |-> r_s1_meta.emit)
        else $error("interior pixel marked as not emitted");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ((CW'(w_c1) < r_w) && (w_r1w < r_h)))
        else $error("accepted pixel placed outside the frame");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_meta.last) |-> w_meta.emit)
        else $error("frame end on a pixel that emits no result");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the 3x3 convolution filter: raster streams against a line-buffer model.
module tb_top;
    import c3cf_pkg::*;

    localparam int unsigned MAX_W         = 4096;
    localparam int unsigned MAX_H         = 4096;
    localparam int unsigned FRAC          = 8;
    localparam int unsigned CLK_HALF      = 4;
    localparam int unsigned RAND_ITEMS    = 1550;
    localparam int unsigned WIDE_ITEMS    = 128;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    typedef enum int {
        K_IDENT, K_BOX, K_SHARPEN, K_EDGE, K_HALF, K_SMALL, K_FULL, K_EXTREME, K_COUNT
    } t_kernel_style;

    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} t_ready_mode;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_src_pixel;

    // Index 0 is the top kernel row.
    typedef logic [2:0][COEF_ROW_W-1:0] t_kernel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    c3cf_pix_in_if  pix_if ();
    c3cf_pix_out_if res_if ();
    c3cf_cfg_if     cfg_if ();

    conv3x3_clamp_filter_unit #(
        .MAX_WIDTH      (MAX_W),
        .MAX_HEIGHT     (MAX_H),
        .COEF_FRAC_BITS (FRAC)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pix_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Filter state as the block should hold it.
    logic [PIX_W-1:0]      line_hi [MAX_W];
    logic [PIX_W-1:0]      line_lo [MAX_W];
    logic [PIX_W-1:0]      win_q [6];
    int unsigned           pos_row;
    int unsigned           pos_col;
    t_kernel               k_rows;
    logic [DIM_W-1:0]      cfg_width;
    logic [DIM_W-1:0]      cfg_height;

    t_src_pixel            pending_pix [$];
    t_res                  expected_px [$];
    t_src_pixel            drv_item;

    logic                  in_fire;
    int unsigned           burst_left;
    int unsigned           gap_left;
    t_ready_mode           rdy_mode;
    int unsigned           rdy_hold;
    int unsigned           rdy_phase;

    int unsigned           error_count;
    int unsigned           results_checked;
    int unsigned           pixels_sent;
    int unsigned           settings_used;
    longint unsigned       cycle_count;

    function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic int coef_of(logic [COEF_ROW_W-1:0] row, int slot);
        logic [COEF_W-1:0] raw;
        raw = row[32 - 16 * slot +: COEF_W];
        return int'($signed(raw));
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [COEF_ROW_W-1:0] val);
        case (idx)
            CFG_COEF_TOP:   k_rows[0] = val;
            CFG_COEF_MID:   k_rows[1] = val;
            CFG_COEF_BOT:   k_rows[2] = val;
            CFG_IMG_WIDTH:  cfg_width = val[DIM_W-1:0];
            CFG_IMG_HEIGHT: cfg_height = val[DIM_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the filter by one source pixel and queues the output pixel it yields.
    function automatic void filter_step(logic [PIX_W-1:0] p, logic fs);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] tap [3][3];
        longint           acc;
        longint           q;
        t_res             res;
        w = dim_in_use(cfg_width, MAX_W);
        h = dim_in_use(cfg_height, MAX_H);
        r = pos_row;
        c = pos_col;
        if (fs) begin
            r = 0;
            c = 0;
        end
        // A size that shrank under the current position wraps it.
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;

        a = line_hi[c];
        b = line_lo[c];
        line_hi[c] = b;
        line_lo[c] = p;

        if (r >= 1 && c >= 1) begin
            res.pixel = PIX_MIN;
            if (r >= 2 && c >= 2) begin
                for (int i = 0; i < 3; i++) begin
                    tap[i][0] = win_q[i];
                    tap[i][1] = win_q[3 + i];
                end
                tap[0][2] = a;
                tap[1][2] = b;
                tap[2][2] = p;
                acc = 0;
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        acc += longint'(tap[i][j]) * longint'(coef_of(k_rows[i], j));
                    end
                end
                if (FRAC > 0) acc += longint'(1) << (FRAC - 1);
                if (acc > 0) begin
                    q = acc >>> FRAC;
                    res.pixel = (q > 255) ? PIX_MAX : PIX_W'(q);
                end
            end
            res.row  = POS_W'(r - 1);
            res.col  = POS_W'(c - 1);
            res.last = (r == h - 1) && (c == w - 1);
            expected_px.push_back(res);
        end

        win_q[0] = win_q[3];
        win_q[1] = win_q[4];
        win_q[2] = win_q[5];
        win_q[3] = a;
        win_q[4] = b;
        win_q[5] = p;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    function automatic void check_result();
        t_res want;
        if (expected_px.size() == 0) begin
            $error("Unexpected output pixel at row %0d col %0d", res_if.out_row, res_if.out_col);
            error_count++;
        end else begin
            want = expected_px.pop_front();
            results_checked++;
            if (res_if.pixel_out !== want.pixel) begin
                $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel,
                       res_if.pixel_out);
                error_count++;
            end
            if (res_if.out_row !== want.row) begin
                $error("out_row mismatch: expected %0d, actual %0d", want.row, res_if.out_row);
                error_count++;
            end
            if (res_if.out_col !== want.col) begin
                $error("out_col mismatch: expected %0d, actual %0d", want.col, res_if.out_col);
                error_count++;
            end
            if (res_if.frame_last !== want.last) begin
                $error("frame_last mismatch: expected %0d, actual %0d", want.last,
                       res_if.frame_last);
                error_count++;
            end
        end
    endfunction

    function automatic t_kernel make_kernel(t_kernel_style style);
        t_kernel           k;
        logic [COEF_W-1:0] tap [3][3];
        logic [COEF_W-1:0] pick;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) tap[i][j] = '0;
        end
        case (style)
            K_IDENT: tap[1][1] = 16'h0100;
            K_BOX: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) tap[i][j] = 16'd28;
                end
            end
            K_SHARPEN: begin
                tap[1][1] = 16'h0500;
                tap[0][1] = 16'hFF00;
                tap[1][0] = 16'hFF00;
                tap[1][2] = 16'hFF00;
                tap[2][1] = 16'hFF00;
            end
            K_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) tap[i][j] = 16'hFF00;
                end
                tap[1][1] = 16'h0800;
            end
            // A half at the centre puts odd pixels exactly on a rounding tie.
            K_HALF: tap[1][1] = 16'h0080;
            K_SMALL: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        tap[i][j] = COEF_W'($urandom_range(0, 192)) - 16'd96;
                    end
                end
            end
            K_FULL: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) tap[i][j] = COEF_W'($urandom);
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 3))
                        0:       pick = 16'h0000;
                        1:       pick = 16'hFFFF;
                        2:       pick = 16'h7FFF;
                        default: pick = 16'h8000;
                    endcase
                    for (int j = 0; j < 3; j++) tap[i][j] = pick;
                end
            end
        endcase
        for (int i = 0; i < 3; i++) k[i] = {tap[i][0], tap[i][1], tap[i][2]};
        return k;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return PIX_MIN;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic void push_pixel(logic [PIX_W-1:0] p, logic fs);
        t_src_pixel item;
        item.pixel       = p;
        item.frame_start = fs;
        pending_pix.push_back(item);
        pixels_sent++;
    endfunction

    // Leaves valid high after the write; the next write or cfg_release takes it over.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_ROW_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setup(logic [DIM_W-1:0] w_reg, logic [DIM_W-1:0] h_reg,
                               t_kernel_style style);
        t_kernel k;
        k = make_kernel(style);
        cfg_write(CFG_COEF_TOP, k[0]);
        cfg_write(CFG_COEF_MID, k[1]);
        cfg_write(CFG_COEF_BOT, k[2]);
        // Indexes past the register list must be ignored.
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(CFG_IDX_W'(int'(CFG_IMG_HEIGHT) + $urandom_range(1, 3)),
                      COEF_ROW_W'({$urandom, $urandom}));
        end
        cfg_write(CFG_IMG_WIDTH, COEF_ROW_W'(w_reg));
        cfg_write(CFG_IMG_HEIGHT, COEF_ROW_W'(h_reg));
        cfg_release();
        settings_used++;
    endtask

    // Returns once every queued pixel has gone in and every output pixel has come out.
    task automatic wait_idle();
        while (pending_pix.size() != 0 || pix_if.valid) @(posedge i_clk);
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Source side: bursts of random length separated by short gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                pix_if.valid <= 1'b0;
            end else if (pending_pix.size() != 0) begin
                drv_item = pending_pix.pop_front();
                pix_if.pixel_in    <= drv_item.pixel;
                pix_if.frame_start <= drv_item.frame_start;
                pix_if.valid       <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                              : $urandom_range(1, 24);
                    gap_left = $urandom_range(1, 7);
                end
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Sink side: the stall pattern switches at random among four modes.
    always @(negedge i_clk) begin
        if (rdy_hold == 0) begin
            rdy_mode = t_ready_mode'($urandom_range(0, 3));
            rdy_hold = $urandom_range(20, 300);
        end
        rdy_hold--;
        rdy_phase++;
        case (rdy_mode)
            RDY_ALWAYS: res_if.ready <= 1'b1;
            RDY_MOSTLY: res_if.ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: res_if.ready <= ($urandom_range(0, 3) == 0);
            default:    res_if.ready <= ((rdy_phase % 6) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d output pixels still outstanding",
                     cycle_count, expected_px.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            in_fire = i_rst_n && pix_if.valid && pix_if.ready;
            if (i_rst_n && cfg_if.valid && cfg_if.ready) write_register(cfg_if.index, cfg_if.data);
            if (in_fire) filter_step(pix_if.pixel_in, pix_if.frame_start);
            if (i_rst_n && res_if.valid && res_if.ready) check_result();
        end
    end

    initial begin
        int unsigned   w_reg;
        int unsigned   h_reg;
        int unsigned   wu;
        int unsigned   hu;
        int unsigned   n;
        int unsigned   frames;
        int unsigned   rand_start;
        t_kernel_style style;
        logic          fs;

        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_in    = '0;
        pix_if.frame_start = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        in_fire            = 1'b0;

        k_rows[0]  = COEF_TOP_RST;
        k_rows[1]  = COEF_MID_RST;
        k_rows[2]  = COEF_BOT_RST;
        cfg_width  = WIDTH_RST;
        cfg_height = HEIGHT_RST;
        for (int i = 0; i < 6; i++) win_q[i] = '0;
        for (int i = 0; i < MAX_W; i++) begin
            line_hi[i] = '0;
            line_lo[i] = '0;
        end
        pos_row = 0;
        pos_col = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The kernel keeps its reset value here; only the frame size is written.
        cfg_write(CFG_IMG_WIDTH, COEF_ROW_W'(3));
        cfg_write(CFG_IMG_HEIGHT, COEF_ROW_W'(3));
        cfg_release();
        settings_used++;
        for (int k = 0; k < 9; k++) push_pixel(((k % 2) == 0) ? PIX_MAX : PIX_MIN, k == 0);
        wait_idle();

        // Sharpen on alternating black and white saturates both ways; stop inside row 2.
        apply_setup(13'd5, 13'd5, K_SHARPEN);
        for (int k = 0; k < 14; k++) push_pixel((k % 2) ? PIX_MAX : PIX_MIN, k == 0);
        wait_idle();

        // Shrink both sizes below the minimum; the next pixel wraps column and row at once.
        apply_setup(13'd0, 13'd2, K_HALF);
        for (int k = 0; k < 9; k++) begin
            push_pixel((k == 2 || k == 8) ? PIX_MAX : PIX_W'(2 * $urandom_range(0, 127) + 1),
                       1'b0);
        end
        wait_idle();

        rand_start = pixels_sent;
        while (pixels_sent - rand_start < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_reg = $urandom_range(0, 2);
                1:       w_reg = $urandom_range(13, 40);
                default: w_reg = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h_reg = $urandom_range(0, 2);
                1:       h_reg = $urandom_range(9, 16);
                default: h_reg = $urandom_range(3, 7);
            endcase
            style = t_kernel_style'($urandom_range(0, int'(K_COUNT) - 1));
            apply_setup(DIM_W'(w_reg), DIM_W'(h_reg), style);
            wu = dim_in_use(DIM_W'(w_reg), MAX_W);
            hu = dim_in_use(DIM_W'(h_reg), MAX_H);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                n = wu * hu;
                // Now and then a frame is cut short and the next one starts early.
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
                for (int k = 0; k < n; k++) begin
                    fs = (k == 0) && (f == 0 || $urandom_range(0, 3) != 0);
                    if ($urandom_range(0, 59) == 0) fs = 1'b1;
                    push_pixel(rand_pixel(), fs);
                end
            end
            wait_idle();
        end

        // Widest setting: the register's top value clamps to the largest width, so a short
        // run stays within row 0 and yields no output pixel.
        apply_setup(13'h1FFF, 13'd0, K_SMALL);
        for (int k = 0; k < WIDE_ITEMS; k++) push_pixel(rand_pixel(), k == 0);
        wait_idle();

        // Tallest setting on the narrowest frame, fed only twenty rows.
        apply_setup(13'h1FFF, 13'd0, K_BOX);
        apply_setup(13'd3, 13'h1FFF, K_BOX);
        for (int k = 0; k < 60; k++) push_pixel(rand_pixel(), k == 0);
        wait_idle();

        $display("Checked %0d output pixels from %0d source pixels under %0d register settings.",
                 results_checked, pixels_sent, settings_used);
        $display("Frames from 3x3 up to the widest row, kernels from identity to saturating.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
